/* hw/rtl/ct3_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 census transform.
// No dependencies; every other file in hw/rtl but ct3_ram refers to this package by scope.
package ct3_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int MIN_DIM      = 3;

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(HEIGHT_LIMIT);
    localparam int CFG_W     = 12;
    localparam int PIX_W     = 8;
    localparam int CODE_W    = 8;
    localparam int CFG_IDX_W = 1;

    // output queue, depth must be a power of two
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef logic [COL_W-1:0]   col_t;
    typedef logic [ROW_W-1:0]   row_t;
    typedef logic [CFG_W-1:0]   cfg_t;
    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [OUTQ_AW-1:0] outq_ptr_t;
    typedef logic [OUTQ_CW-1:0] outq_cnt_t;

    localparam cfg_t WIDTH_RESET  = 12'd640;
    localparam cfg_t HEIGHT_RESET = 12'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_DRAIN = 1'b1
    } mode_t;

    // census bit positions
    localparam int BIT_UP_LEFT    = 0;
    localparam int BIT_UP         = 1;
    localparam int BIT_UP_RIGHT   = 2;
    localparam int BIT_LEFT       = 3;
    localparam int BIT_RIGHT      = 4;
    localparam int BIT_DOWN_LEFT  = 5;
    localparam int BIT_DOWN       = 6;
    localparam int BIT_DOWN_RIGHT = 7;

    // item between the address stage and the window stage
    typedef struct packed {
        logic is_drain;
        logic drain_eof;
        pix_t pixel;
        col_t col;
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic col_last;
    } stage_t;

    typedef struct packed {
        code_t census_code;
        logic  last_of_item;
        logic  end_of_frame;
    } result_t;

endpackage

/* hw/rtl/ct3_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel input and census code output.
// Depends on ct3_pkg for payload types.
interface ct3_in_if;
    logic          valid;
    logic          ready;
    logic          mode;
    ct3_pkg::pix_t pixel;

    modport source (output valid, output mode, output pixel, input ready);
    modport sink   (input valid, input mode, input pixel, output ready);
endinterface

interface ct3_out_if;
    logic           valid;
    logic           ready;
    ct3_pkg::code_t census_code;
    logic           last_of_item;
    logic           end_of_frame;

    modport source (output valid, output census_code, output last_of_item,
                    output end_of_frame, input ready);
    modport sink   (input valid, input census_code, input last_of_item,
                    input end_of_frame, output ready);
endinterface

/* hw/rtl/ct3_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ct3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/ct3_ctrl.sv */
`timescale 1ns / 1ps
// Address stage: row, column and drain counters, line store read issue,
// and the stage register that feeds the window stage. Uses ct3_pkg, ct3_if.
module ct3_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    ct3_in_if.sink           pix_in,
    input  ct3_pkg::col_t    last_col,
    input  ct3_pkg::row_t    last_row,
    input  logic             s1_fire,
    output logic             s1_valid,
    output ct3_pkg::stage_t  s1_data,
    output logic             rd_en,
    output ct3_pkg::col_t    rd_addr
);

    ct3_pkg::col_t   col_reg, col_next;
    ct3_pkg::row_t   row_reg, row_next;
    ct3_pkg::col_t   drain_reg, drain_next;
    logic            s1_valid_reg, s1_valid_next;
    ct3_pkg::stage_t s1_data_reg, s1_data_next;

    logic            accept;
    logic            is_drain;
    logic            drain_eof;
    logic            col_end;
    ct3_pkg::col_t   col_cur;
    ct3_pkg::stage_t stage;

    assign pix_in.ready = !s1_valid_reg || s1_fire;
    assign accept       = pix_in.valid && pix_in.ready;
    assign is_drain     = (pix_in.mode == ct3_pkg::MODE_DRAIN);

    // a column past the row end counts as the last column
    assign col_cur   = (col_reg > last_col) ? last_col : col_reg;
    assign col_end   = (col_cur == last_col);
    assign drain_eof = (drain_reg >= last_col);

    always_comb
    begin
        stage.is_drain  = is_drain;
        stage.drain_eof = drain_eof;
        stage.pixel     = pix_in.pixel;
        stage.col       = col_cur;
        stage.row_ge1   = (row_reg != '0);
        stage.row_ge2   = (row_reg >= ct3_pkg::row_t'(2));
        stage.col_ge1   = (col_cur != '0);
        stage.col_ge2   = (col_cur >= ct3_pkg::col_t'(2));
        stage.col_last  = col_end;
    end

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        s1_valid_next = s1_valid_reg;
        s1_data_next  = s1_data_reg;
        if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_data_next  = stage;
            if (is_drain)
            begin
                drain_next = drain_eof ? '0 : drain_reg + 1'b1;
            end
            else if (col_end)
            begin
                col_next = '0;
                row_next = (row_reg >= last_row) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_data_reg <= s1_data_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_data  = s1_data_reg;
    assign rd_en    = accept && !is_drain;
    assign rd_addr  = col_cur;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_data_reg))
        else $error("window stage word lost or changed while stalled");

    a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_drain && col_end |=> col_reg == '0)
        else $error("column counter did not restart after row end");

endmodule

/* hw/rtl/ct3_window.sv */
`timescale 1ns / 1ps
// Window stage: 3x3 window columns, census compare, line store write-back,
// and the result words for one item. Uses ct3_pkg.
module ct3_window (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s1_valid,
    input  ct3_pkg::stage_t   s1_data,
    input  logic              room,
    input  ct3_pkg::pix_t     top_px,
    input  ct3_pkg::pix_t     mid_px,
    output logic              s1_fire,
    output logic              wr_en,
    output ct3_pkg::col_t     wr_addr,
    output ct3_pkg::pix_t     wr_data_a,
    output ct3_pkg::pix_t     wr_data_b,
    output logic [1:0]        push_n,
    output ct3_pkg::result_t  res0,
    output ct3_pkg::result_t  res1
);

    // columns c-2 and c-1 as (top, mid, bottom)
    ct3_pkg::pix_t   win_reg [6];
    ct3_pkg::pix_t   win_next [6];
    ct3_pkg::pix_t   ctr;
    ct3_pkg::code_t  code;
    logic            emit_code;
    logic            emit_edge;
    logic [1:0]      n_words;

    assign s1_fire   = s1_valid && room;
    assign wr_en     = s1_fire && !s1_data.is_drain;
    assign wr_addr   = s1_data.col;
    assign wr_data_a = s1_data.pixel;
    assign wr_data_b = mid_px;

    assign ctr = win_reg[4];

    always_comb
    begin
        code = '0;
        if (s1_data.row_ge2 && s1_data.col_ge2)
        begin
            code[ct3_pkg::BIT_UP_LEFT]    = (win_reg[0] >= ctr);
            code[ct3_pkg::BIT_UP]         = (win_reg[3] >= ctr);
            code[ct3_pkg::BIT_UP_RIGHT]   = (top_px >= ctr);
            code[ct3_pkg::BIT_LEFT]       = (win_reg[1] >= ctr);
            code[ct3_pkg::BIT_RIGHT]      = (mid_px >= ctr);
            code[ct3_pkg::BIT_DOWN_LEFT]  = (win_reg[2] >= ctr);
            code[ct3_pkg::BIT_DOWN]       = (win_reg[5] >= ctr);
            code[ct3_pkg::BIT_DOWN_RIGHT] = (s1_data.pixel >= ctr);
        end
    end

    assign emit_code = s1_data.row_ge1 && s1_data.col_ge1;
    assign emit_edge = s1_data.row_ge1 && s1_data.col_last;

    always_comb
    begin
        res0    = '0;
        res1    = '0;
        n_words = 2'd0;
        if (s1_data.is_drain)
        begin
            n_words           = 2'd1;
            res0.last_of_item = 1'b1;
            res0.end_of_frame = s1_data.drain_eof;
        end
        else if (emit_code && emit_edge)
        begin
            // code for the last interior column, then the right border zero
            n_words           = 2'd2;
            res0.census_code  = code;
            res1.last_of_item = 1'b1;
        end
        else if (emit_code)
        begin
            n_words           = 2'd1;
            res0.census_code  = code;
            res0.last_of_item = 1'b1;
        end
        else if (emit_edge)
        begin
            n_words           = 2'd1;
            res0.last_of_item = 1'b1;
        end
    end

    assign push_n = s1_fire ? n_words : 2'd0;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            win_next[i] = win_reg[i];
        end
        if (wr_en)
        begin
            win_next[0] = win_reg[3];
            win_next[1] = win_reg[4];
            win_next[2] = win_reg[5];
            win_next[3] = top_px;
            win_next[4] = mid_px;
            win_next[5] = s1_data.pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

/* hw/rtl/ct3_outq.sv */
`timescale 1ns / 1ps
// Output queue: takes up to two result words per cycle, hands one per cycle
// to the output channel while it is ready. Uses ct3_pkg, ct3_if.
module ct3_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_n,
    input  ct3_pkg::result_t  res0,
    input  ct3_pkg::result_t  res1,
    output logic              room,
    ct3_out_if.source         code_out
);

    ct3_pkg::result_t   queue_reg [ct3_pkg::OUTQ_DEPTH];
    ct3_pkg::outq_ptr_t wr_ptr_reg, wr_ptr_next;
    ct3_pkg::outq_ptr_t rd_ptr_reg, rd_ptr_next;
    ct3_pkg::outq_cnt_t count_reg, count_next;
    ct3_pkg::outq_ptr_t wr_ptr_inc;
    ct3_pkg::result_t   head;
    logic               pop;

    assign pop        = code_out.valid && code_out.ready;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    // registered fill level only, so output ready never reaches input ready
    assign room = (count_reg <= ct3_pkg::outq_cnt_t'(ct3_pkg::OUTQ_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + ct3_pkg::outq_ptr_t'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + ct3_pkg::outq_cnt_t'(push_n)
                      - ct3_pkg::outq_cnt_t'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_inc] <= res1;
        end
    end

    assign head                  = queue_reg[rd_ptr_reg];
    assign code_out.valid        = (count_reg != '0);
    assign code_out.census_code  = head.census_code;
    assign code_out.last_of_item = head.last_of_item;
    assign code_out.end_of_frame = head.end_of_frame;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ct3_pkg::outq_cnt_t'(ct3_pkg::OUTQ_DEPTH))
        else $error("output queue overflow");

    a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
        pop && push_n == 2'd0 |=> count_reg == $past(count_reg) - 1'b1)
        else $error("output queue level wrong after a pop");

endmodule

/* hw/rtl/census_transform_3x3_unit.sv */
`timescale 1ns / 1ps
// Top level of the streaming 3x3 census transform: configuration registers,
// line stores and the stage modules. Uses ct3_pkg, ct3_if, ct3_ram, ct3_ctrl,
// ct3_window, ct3_outq.
//
//  Channel    Dir  Handshake        Word
//  pix_in     in   valid/ready      mode, pixel
//  code_out   out  valid/ready      census_code, last_of_item, end_of_frame
//  cfg        in   cfg_we only      cfg_index, cfg_data (no read-back)
//
//  One input word per cycle sustained while the output queue has room. A result
//  word passes the stage register and line store read, then the output queue.
//  Row-end pixels after the first row give two words; the four-word output queue
//  absorbs them and input stalls only while the queue holds three or more words.
//  Line stores need no clearing after reset; the block takes words from the
//  first cycle after rst_n rises.
module census_transform_3x3_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    ct3_in_if.sink                             pix_in,
    ct3_out_if.source                          code_out,
    input  logic                               cfg_we,
    input  logic [ct3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  ct3_pkg::cfg_t                      cfg_data
);

    ct3_pkg::cfg_t    image_width_reg, image_width_next;
    ct3_pkg::cfg_t    image_height_reg, image_height_next;
    ct3_pkg::col_t    last_col;
    ct3_pkg::row_t    last_row;

    logic             s1_valid;
    logic             s1_fire;
    ct3_pkg::stage_t  s1_data;
    logic             rd_en;
    ct3_pkg::col_t    rd_addr;
    logic             wr_en;
    ct3_pkg::col_t    wr_addr;
    ct3_pkg::pix_t    wr_data_a;
    ct3_pkg::pix_t    wr_data_b;
    ct3_pkg::pix_t    top_px;
    ct3_pkg::pix_t    mid_px;
    logic             room;
    logic [1:0]       push_n;
    ct3_pkg::result_t res0;
    ct3_pkg::result_t res1;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_we)
        begin
            unique case (ct3_pkg::cfg_index_t'(cfg_index))
                ct3_pkg::CFG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                ct3_pkg::CFG_IMAGE_HEIGHT: image_height_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= ct3_pkg::WIDTH_RESET;
            image_height_reg <= ct3_pkg::HEIGHT_RESET;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // clamp width and height into range, keep the last index
    always_comb
    begin
        if (32'(image_width_reg) < ct3_pkg::MIN_DIM)
        begin
            last_col = ct3_pkg::col_t'(ct3_pkg::MIN_DIM - 1);
        end
        else if (32'(image_width_reg) > ct3_pkg::MAX_WIDTH)
        begin
            last_col = ct3_pkg::col_t'(ct3_pkg::MAX_WIDTH - 1);
        end
        else
        begin
            last_col = ct3_pkg::col_t'(image_width_reg - 1'b1);
        end

        if (32'(image_height_reg) < ct3_pkg::MIN_DIM)
        begin
            last_row = ct3_pkg::row_t'(ct3_pkg::MIN_DIM - 1);
        end
        else if (32'(image_height_reg) > ct3_pkg::HEIGHT_LIMIT)
        begin
            last_row = ct3_pkg::row_t'(ct3_pkg::HEIGHT_LIMIT - 1);
        end
        else
        begin
            last_row = ct3_pkg::row_t'(image_height_reg - 1'b1);
        end
    end

    ct3_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .last_col (last_col),
        .last_row (last_row),
        .s1_fire  (s1_fire),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr)
    );

    // previous row
    ct3_ram #(
        .WIDTH (ct3_pkg::PIX_W),
        .DEPTH (ct3_pkg::MAX_WIDTH)
    ) u_line_a (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data_a),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (mid_px)
    );

    // row before that
    ct3_ram #(
        .WIDTH (ct3_pkg::PIX_W),
        .DEPTH (ct3_pkg::MAX_WIDTH)
    ) u_line_b (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data_b),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (top_px)
    );

    ct3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_data   (s1_data),
        .room      (room),
        .top_px    (top_px),
        .mid_px    (mid_px),
        .s1_fire   (s1_fire),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data_a (wr_data_a),
        .wr_data_b (wr_data_b),
        .push_n    (push_n),
        .res0      (res0),
        .res1      (res1)
    );

    ct3_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_n   (push_n),
        .res0     (res0),
        .res1     (res1),
        .room     (room),
        .code_out (code_out)
    );

endmodule
